/* rtl/core/heightfield_triangle_interpolation_defines.svh */
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef HEIGHTFIELD_TRIANGLE_INTERPOLATION_DEFINES_SVH
`define HEIGHTFIELD_TRIANGLE_INTERPOLATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/hti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hti_pkg;

	localparam int HW = 24;

	// Stream payload widths.
	localparam int IN_TDATA_W  = 88;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 24;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] FUNC_CORNER = 2'd0;
	localparam logic [1:0] FUNC_CENTRE = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	// Configuration port.
	localparam int APB_AW = 3;
	localparam logic REG_TILE_PRESENT = 1'b0;

	// Shared multiplier operand and product widths.
	localparam int MUL_AW = 28;
	localparam int MUL_BW = 27;
	localparam int MUL_PW = 55;

	// ceil(2^30 / 25): exact quotient by 25 for any operand below 2^25.
	localparam logic [25:0] RECIP25 = 26'd42949673;
	// 25 * 2^19, lifts a signed coordinate into the non-negative range.
	localparam logic [24:0] X_OFFSET = 25'd13107200;

	localparam logic signed [31:0] H_MAX = 32'sd8388607;
	localparam logic signed [31:0] H_MIN = -32'sd8388608;

	typedef struct packed {
		logic          corner_en;
		logic          centre_en;
		logic [7:0]    row;
		logic [7:0]    col;
		logic [HW-1:0] value;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	// floor((1536 * r + 12) / 25) for the remainder r of a division by 25.
	function automatic logic [10:0] frac_table(input logic [4:0] r);
		logic [10:0] v;
		case (r)
			5'd0:  v = 11'd0;
			5'd1:  v = 11'd61;
			5'd2:  v = 11'd123;
			5'd3:  v = 11'd184;
			5'd4:  v = 11'd246;
			5'd5:  v = 11'd307;
			5'd6:  v = 11'd369;
			5'd7:  v = 11'd430;
			5'd8:  v = 11'd492;
			5'd9:  v = 11'd553;
			5'd10: v = 11'd614;
			5'd11: v = 11'd676;
			5'd12: v = 11'd737;
			5'd13: v = 11'd799;
			5'd14: v = 11'd860;
			5'd15: v = 11'd922;
			5'd16: v = 11'd983;
			5'd17: v = 11'd1044;
			5'd18: v = 11'd1106;
			5'd19: v = 11'd1167;
			5'd20: v = 11'd1229;
			5'd21: v = 11'd1290;
			5'd22: v = 11'd1352;
			5'd23: v = 11'd1413;
			5'd24: v = 11'd1475;
			default: v = 11'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/hti_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module hti_mul (
	input  wire                                      clk,
	input  wire hti_pkg::mul_req_t                   req,
	output logic signed [hti_pkg::MUL_PW-1:0]        prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= $signed(req.a) * $signed(req.b);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/hti_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module hti_store #(
	parameter  int GRID_CELLS = 128,
	localparam int CAW = $clog2((GRID_CELLS + 1) * (GRID_CELLS + 1)),
	localparam int CEW = $clog2(GRID_CELLS * GRID_CELLS)
) (
	input  wire                          clk,
	input  wire hti_pkg::wr_req_t        wr,
	input  wire [CAW-1:0]                corner_raddr,
	input  wire [CEW-1:0]                centre_raddr,
	output logic [hti_pkg::HW-1:0]       corner_rdata_q,
	output logic [hti_pkg::HW-1:0]       centre_rdata_q
);

	localparam int CSIDE = GRID_CELLS + 1;

	logic [hti_pkg::HW-1:0] corner_mem [CSIDE * CSIDE];
	logic [hti_pkg::HW-1:0] centre_mem [GRID_CELLS * GRID_CELLS];

	logic [CAW-1:0] corner_waddr;
	logic [CEW-1:0] centre_waddr;

	assign corner_waddr = CAW'(32'(wr.row) * CSIDE + 32'(wr.col));
	assign centre_waddr = CEW'(32'(wr.row) * GRID_CELLS + 32'(wr.col));

	always_ff @(posedge clk) begin
		if (wr.corner_en) begin
			corner_mem[corner_waddr] <= wr.value;
		end
		corner_rdata_q <= corner_mem[corner_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.centre_en) begin
			centre_mem[centre_waddr] <= wr.value;
		end
		centre_rdata_q <= centre_mem[centre_raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/hti_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module hti_seq #(
	parameter  int GRID_CELLS = 128,
	localparam int CAW = $clog2((GRID_CELLS + 1) * (GRID_CELLS + 1)),
	localparam int CEW = $clog2(GRID_CELLS * GRID_CELLS)
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  tile_present,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire [hti_pkg::IN_TDATA_W-1:0]        s_tdata,
	input  wire [hti_pkg::IN_TUSER_W-1:0]        s_tuser,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [hti_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                 m_tuser,
	output hti_pkg::wr_req_t                     wr,
	output logic [CAW-1:0]                       corner_raddr,
	output logic [CEW-1:0]                       centre_raddr,
	input  wire [hti_pkg::HW-1:0]                corner_rdata,
	input  wire [hti_pkg::HW-1:0]                centre_rdata,
	output hti_pkg::mul_req_t                    mul_req,
	input  wire signed [hti_pkg::MUL_PW-1:0]     prod_q
);

	localparam int CW = $clog2(GRID_CELLS);
	localparam int CSIDE = GRID_CELLS + 1;
	localparam int MOD_RECIP = (2**26 + GRID_CELLS - 1) / GRID_CELLS;
	localparam logic [8:0] GRID9 = 9'(GRID_CELLS);
	localparam logic [17:0] IP_OFFSET = 18'(GRID_CELLS * 256);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_GRID = 12'b0000_0000_0010,
		ST_INT  = 12'b0000_0000_0100,
		ST_MOD  = 12'b0000_0000_1000,
		ST_CELL = 12'b0000_0001_0000,
		ST_READ = 12'b0000_0010_0000,
		ST_LAST = 12'b0000_0100_0000,
		ST_COEF = 12'b0000_1000_0000,
		ST_MULA = 12'b0001_0000_0000,
		ST_MULB = 12'b0010_0000_0000,
		ST_SUM  = 12'b0100_0000_0000,
		ST_EMIT = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   sel_y_q;
	logic [1:0] rd_cnt_q;
	logic   m_tvalid_q;

	logic [23:0] px_q, py_q;
	logic [15:0] fx_q, fy_q;
	logic [CW-1:0] cx_q, cy_q;
	logic [16:0] ip_q;
	logic [hti_pkg::HW-1:0] h_q [4];
	logic signed [27:0] a_q, b_q, c_q;
	logic signed [47:0] acc_q;
	logic [23:0] res_h_q, out_h_q;
	logic res_nl_q, out_nl_q;

	logic [1:0]  in_func;
	logic [7:0]  in_row, in_col;
	logic [23:0] in_val, in_px, in_py;
	logic accept, out_load;
	logic corner_ok, centre_ok;

	logic [24:0] xp;
	logic [19:0] q_rcp;
	logic [4:0]  r_lo;
	logic [31:0] g_val;
	logic [17:0] ip_new;
	logic [12:0] qg;
	logic [16:0] cell_full;
	logic [CW-1:0] cell_idx;

	logic signed [27:0] h1, h2, h3, h4, h5;
	logic signed [27:0] a_new, b_new, c_new;
	logic [16:0] fsum;
	logic signed [47:0] acc_new, sum_all;
	logic signed [31:0] t_val;
	logic [23:0] sat_h;

	assign in_func = s_tuser;
	assign in_row  = s_tdata[7:0];
	assign in_col  = s_tdata[15:8];
	assign in_val  = s_tdata[39:16];
	assign in_px   = s_tdata[63:40];
	assign in_py   = s_tdata[87:64];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_h_q;
	assign m_tuser  = out_nl_q;

	// Writes land in the store in the beat they are accepted.
	assign corner_ok = ({1'b0, in_row} <= GRID9) && ({1'b0, in_col} <= GRID9);
	assign centre_ok = ({1'b0, in_row} < GRID9) && ({1'b0, in_col} < GRID9);

	always_comb begin
		wr           = '0;
		wr.row       = in_row;
		wr.col       = in_col;
		wr.value     = in_val;
		wr.corner_en = accept && (in_func == hti_pkg::FUNC_CORNER) && corner_ok;
		wr.centre_en = accept && (in_func == hti_pkg::FUNC_CENTRE) && centre_ok;
	end

	// Grid mapping: G = 2^30 - 1536*q - T[r] with xp = 25*q + r.
	assign xp     = (sel_y_q ? {py_q[23], py_q} : {px_q[23], px_q}) + hti_pkg::X_OFFSET;
	assign q_rcp  = prod_q[49:30];
	assign r_lo   = xp[4:0] - 5'(q_rcp[4:0] * 5'd25);
	assign g_val  = 32'h4000_0000 - {1'b0, 22'(q_rcp) * 22'd3, 9'b0}
		- 32'(hti_pkg::frac_table(r_lo));
	assign ip_new = {{2{g_val[31]}}, g_val[31:16]} + IP_OFFSET;

	// Cell index is the integer part reduced modulo the grid size.
	assign qg        = prod_q[38:26];
	assign cell_full = ip_q - 17'(32'(qg) * GRID_CELLS);
	assign cell_idx  = cell_full[CW-1:0];

	// Corner reads go h1, h2 (x+1), h3 (y+1), h4 (x+1, y+1).
	assign corner_raddr = CAW'((32'(cx_q) + 32'(rd_cnt_q[0])) * CSIDE
		+ 32'(cy_q) + 32'(rd_cnt_q[1]));
	assign centre_raddr = CEW'(32'(cx_q) * GRID_CELLS + 32'(cy_q));

	assign h1   = 28'($signed(h_q[0]));
	assign h2   = 28'($signed(h_q[1]));
	assign h3   = 28'($signed(h_q[2]));
	assign h4   = 28'($signed(h_q[3]));
	assign h5   = 28'($signed(centre_rdata)) <<< 1;
	assign fsum = {1'b0, fx_q} + {1'b0, fy_q};

	always_comb begin
		if (!fsum[16]) begin
			c_new = h1;
			if (fx_q > fy_q) begin
				a_new = h2 - h1;
				b_new = h5 - h1 - h2;
			end else begin
				a_new = h5 - h1 - h3;
				b_new = h3 - h1;
			end
		end else begin
			c_new = h5 - h4;
			if (fx_q > fy_q) begin
				a_new = h2 + h4 - h5;
				b_new = h4 - h2;
			end else begin
				a_new = h4 - h3;
				b_new = h3 + h4 - h5;
			end
		end
	end

	// The constant term rides in the accumulator above the rounding bit.
	assign acc_new = 48'(prod_q) + 48'sd32768 + (48'(c_q) <<< 16);
	assign sum_all = acc_q + 48'(prod_q);
	assign t_val   = sum_all[47:16];

	always_comb begin
		if (t_val > hti_pkg::H_MAX) begin
			sat_h = hti_pkg::H_MAX[23:0];
		end else if (t_val < hti_pkg::H_MIN) begin
			sat_h = hti_pkg::H_MIN[23:0];
		end else begin
			sat_h = t_val[23:0];
		end
	end

	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_GRID: begin
				mul_req.en = 1'b1;
				mul_req.a  = {3'b0, xp};
				mul_req.b  = {1'b0, hti_pkg::RECIP25};
			end
			ST_MOD: begin
				mul_req.en = 1'b1;
				mul_req.a  = {11'b0, ip_q};
				mul_req.b  = 27'(MOD_RECIP);
			end
			ST_MULA: begin
				mul_req.en = 1'b1;
				mul_req.a  = a_q;
				mul_req.b  = {11'b0, fx_q};
			end
			ST_MULB: begin
				mul_req.en = 1'b1;
				mul_req.a  = b_q;
				mul_req.b  = {11'b0, fy_q};
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_func == hti_pkg::FUNC_QUERY)) begin
					state_d = tile_present ? ST_GRID : ST_EMIT;
				end
			end
			ST_GRID: state_d = ST_INT;
			ST_INT:  state_d = ST_MOD;
			ST_MOD:  state_d = ST_CELL;
			ST_CELL: state_d = sel_y_q ? ST_READ : ST_GRID;
			ST_READ: begin
				if (rd_cnt_q == 2'd3) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: state_d = ST_COEF;
			ST_COEF: state_d = ST_MULA;
			ST_MULA: state_d = ST_MULB;
			ST_MULB: state_d = ST_SUM;
			ST_SUM:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sel_y_q    <= 1'b0;
			rd_cnt_q   <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				sel_y_q  <= 1'b0;
				rd_cnt_q <= 2'd0;
			end else if (state_q == ST_CELL) begin
				sel_y_q <= 1'b1;
			end else if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 2'd1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_func == hti_pkg::FUNC_QUERY)) begin
					px_q     <= in_px;
					py_q     <= in_py;
					res_h_q  <= '0;
					res_nl_q <= 1'b1;
				end
			end
			ST_INT: begin
				ip_q <= ip_new[16:0];
				if (sel_y_q) begin
					fy_q <= g_val[15:0];
				end else begin
					fx_q <= g_val[15:0];
				end
			end
			ST_CELL: begin
				if (sel_y_q) begin
					cy_q <= cell_idx;
				end else begin
					cx_q <= cell_idx;
				end
			end
			ST_READ: begin
				// Read data arrives in the cycle after its address.
				if (rd_cnt_q != 2'd0) begin
					h_q[rd_cnt_q - 2'd1] <= corner_rdata;
				end
			end
			ST_LAST: begin
				h_q[3] <= corner_rdata;
			end
			ST_COEF: begin
				a_q <= a_new;
				b_q <= b_new;
				c_q <= c_new;
			end
			ST_MULB: begin
				acc_q <= acc_new;
			end
			ST_SUM: begin
				res_h_q  <= sat_h;
				res_nl_q <= 1'b0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_h_q  <= res_h_q;
			out_nl_q <= res_nl_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/heightfield_triangle_interpolation.sv */
// Write beats (corner or centre height) produce no result.
// A query with the tile absent goes through ST_EMIT into the output register with no_land set.
// A query with the tile present steps through ST_GRID, ST_INT, ST_MOD, ST_CELL for x, then y,
// then ST_READ to ST_EMIT, sharing one multiplier and corner read port; input waits for ST_IDLE.
// Reset clears the sequencer state, the output valid and tile_present; height stores keep contents.
`timescale 1ns / 1ps
`default_nettype none

module heightfield_triangle_interpolation #(
	parameter int GRID_CELLS = 128
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [hti_pkg::APB_AW-1:0]           paddr,
	input  wire [31:0]                          pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// grid_row[7:0], grid_col[15:8], height_value[39:16], pos_x[63:40], pos_y[87:64]
	input  wire [hti_pkg::IN_TDATA_W-1:0]       s_tdata,
	// func[1:0]
	input  wire [hti_pkg::IN_TUSER_W-1:0]       s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// height[23:0]
	output logic [hti_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// no_land[0]
	output logic                                m_tuser
);

	localparam int CAW = $clog2((GRID_CELLS + 1) * (GRID_CELLS + 1));
	localparam int CEW = $clog2(GRID_CELLS * GRID_CELLS);

	logic tile_present_q;
	logic cfg_wr;

	hti_pkg::wr_req_t  wr;
	hti_pkg::mul_req_t mul_req;
	logic signed [hti_pkg::MUL_PW-1:0] prod_q;
	logic [CAW-1:0] corner_raddr;
	logic [CEW-1:0] centre_raddr;
	logic [hti_pkg::HW-1:0] corner_rdata, centre_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == hti_pkg::REG_TILE_PRESENT);
	assign prdata = (paddr[2] == hti_pkg::REG_TILE_PRESENT) ? {31'b0, tile_present_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_present_q <= 1'b0;
		end else if (cfg_wr) begin
			tile_present_q <= pwdata[0];
		end
	end

	hti_seq #(
		.GRID_CELLS(GRID_CELLS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.tile_present (tile_present_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.wr           (wr),
		.corner_raddr (corner_raddr),
		.centre_raddr (centre_raddr),
		.corner_rdata (corner_rdata),
		.centre_rdata (centre_rdata),
		.mul_req      (mul_req),
		.prod_q       (prod_q)
	);

	hti_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	hti_store #(
		.GRID_CELLS(GRID_CELLS)
	) u_store (
		.clk            (clk),
		.wr             (wr),
		.corner_raddr   (corner_raddr),
		.centre_raddr   (centre_raddr),
		.corner_rdata_q (corner_rdata),
		.centre_rdata_q (centre_rdata)
	);

endmodule

`default_nettype wire

/* rtl/core/hti_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "heightfield_triangle_interpolation_defines.svh"

module hti_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  s_tvalid,
	input wire                                  s_tready,
	input wire [hti_pkg::IN_TUSER_W-1:0]        s_tuser,
	input wire                                  m_tvalid,
	input wire                                  m_tready,
	input wire [hti_pkg::OUT_TDATA_W-1:0]       m_tdata,
	input wire                                  m_tuser
);

	// A stalled result beat keeps its payload.
	`HTI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

	// A query occupies the block, so the input side closes right after it.
	`HTI_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == hti_pkg::FUNC_QUERY), !s_tready, "input still ready after a query beat")

	// Height writes and unused codes finish in their own beat.
	`HTI_ASSERT_NEXT(a_write_ready, s_tvalid && s_tready && (s_tuser != hti_pkg::FUNC_QUERY), s_tready, "input not ready after a write beat")

	// An answer for an absent tile carries height zero.
	`HTI_ASSERT_NOW(a_no_land_zero, m_tvalid && m_tuser, m_tdata == '0, "no-land result with nonzero height")

endmodule

bind heightfield_triangle_interpolation hti_checker u_hti_checker (.*);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import hti_pkg::*;

	localparam int CELLS = 128;
	localparam int CSIDE = CELLS + 1;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [APB_AW-1:0] TILE_ADDR = APB_AW'(4 * REG_TILE_PRESENT);
	localparam int POS_TOP = 4369152;
	localparam int SETTLE = 24;
	localparam int LIMIT = 1000000;
	localparam int PHASE_ITEMS = 150;
	localparam bit [4:0] TILE_PLAN = 5'b10101;

	localparam logic [HW-1:0] H_HI = H_MAX[HW-1:0];
	localparam logic [HW-1:0] H_LO = H_MIN[HW-1:0];
	localparam logic [HW-1:0] P_TOP = 24'd4369152;
	localparam logic [HW-1:0] P_BOT = -24'sd4369152;

	typedef struct packed {
		logic [HW-1:0] height;
		logic          no_land;
	} ground_t;

	localparam ground_t ABSENT = '{height: '0, no_land: 1'b1};
	localparam ground_t NONE = '0;
	localparam ground_t LOW_CORNER = '{height: H_LO, no_land: 1'b0};

	typedef struct packed {
		logic          cfg;
		logic          cfg_val;
		logic [1:0]    fn;
		logic [7:0]    row;
		logic [7:0]    col;
		logic [HW-1:0] hv;
		logic [HW-1:0] px;
		logic [HW-1:0] py;
		logic          fixed;
		ground_t       t_res;
	} drow_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	ground_t height_q[$];
	ground_t want;
	logic signed [HW-1:0] corner_mem [CSIDE*CSIDE];
	logic signed [HW-1:0] centre_mem [CELLS*CELLS];
	bit corner_set [CSIDE*CSIDE];
	bit centre_set [CELLS*CELLS];
	bit tile_on;
	int err_cnt;
	int cycle_cnt;
	int items_sent;
	int calm_left [2];

	// Directed rows: tile absent first, an unused code, then the two corner cells of the grid,
	// ignored writes, and queries once the tile is switched on.
	drow_t dir_tab [25] = '{
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, 24'd0, 24'd0, 1'b1, ABSENT},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, P_TOP, P_BOT, 1'b1, ABSENT},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, P_BOT, P_TOP, 1'b1, ABSENT},
		'{1'b0, 1'b0, FUNC_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd0, 8'd0, H_LO, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd1, 8'd0, H_HI, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd0, 8'd1, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd1, 8'd1, 24'd1000, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CENTRE, 8'd0, 8'd0, H_HI, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd127, 8'd127, H_HI, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd128, 8'd127, H_LO, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd127, 8'd128, 24'd5000, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd128, 8'd128, H_HI, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CENTRE, 8'd127, 8'd127, H_LO, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd129, 8'd0, 24'd777, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CENTRE, 8'd128, 8'd5, 24'd777, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_CORNER, 8'd255, 8'd255, 24'd777, 24'd0, 24'd0, 1'b0, NONE},
		'{1'b1, 1'b1, FUNC_QUERY, 8'd0, 8'd0, 24'd0, 24'd0, 24'd0, 1'b1, LOW_CORNER},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, -24'sd1066, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, -24'sd1066, -24'sd1066, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, -24'sd1066, -24'sd500, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, 24'd1, 24'd1, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, P_TOP, 24'd1, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, P_BOT, 24'd0, 1'b0, NONE},
		'{1'b0, 1'b0, FUNC_QUERY, 8'd0, 8'd0, 24'd0, -24'sd500, -24'sd1066, 1'b0, NONE}
	};

	heightfield_triangle_interpolation #(
		.GRID_CELLS(CELLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= 40)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	// Mostly random gaps, with occasional runs of back-to-back beats.
	function automatic int pick_gap(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0)
			calm_left[side] = $urandom_range(10, 40);
		return $urandom_range(0, 14);
	endfunction

	function automatic longint floor_quot(input longint n, input longint d);
		longint q;
		q = n / d;
		if (n % d != 0 && n < 0)
			q--;
		return q;
	endfunction

	// World coordinate to wrapped cell index and Q0.16 fraction.
	function automatic void grid_pos(input logic signed [HW-1:0] coord, output int idx,
			output longint frac);
		longint x, g, whole;
		x = coord;
		g = (longint'(1) <<< 28) - floor_quot(1536 * x + 12, 25);
		whole = floor_quot(g, 65536);
		frac = g - whole * 65536;
		whole = whole % CELLS;
		if (whole < 0)
			whole += CELLS;
		idx = int'(whole);
	endfunction

	function automatic bit ground_height(input logic [1:0] fn, input logic [7:0] row,
			input logic [7:0] col, input logic signed [HW-1:0] hv,
			input logic signed [HW-1:0] px, input logic signed [HW-1:0] py,
			output ground_t res);
		int cx, cy;
		longint fx, fy, a, b, c, h;
		longint h1, h2, h3, h4, h5;
		res = '0;
		case (fn)
			FUNC_CORNER: begin
				if (row <= CELLS && col <= CELLS) begin
					corner_mem[row * CSIDE + col] = hv;
					corner_set[row * CSIDE + col] = 1'b1;
				end
				return 1'b0;
			end
			FUNC_CENTRE: begin
				if (row < CELLS && col < CELLS) begin
					centre_mem[row * CELLS + col] = hv;
					centre_set[row * CELLS + col] = 1'b1;
				end
				return 1'b0;
			end
			FUNC_QUERY: ;
			default: return 1'b0;
		endcase
		if (!tile_on) begin
			res.no_land = 1'b1;
			return 1'b1;
		end
		grid_pos(px, cx, fx);
		grid_pos(py, cy, fy);
		h1 = corner_mem[cx * CSIDE + cy];
		h2 = corner_mem[(cx + 1) * CSIDE + cy];
		h3 = corner_mem[cx * CSIDE + cy + 1];
		h4 = corner_mem[(cx + 1) * CSIDE + cy + 1];
		h5 = 2 * longint'(centre_mem[cx * CELLS + cy]);
		// Lower half of the cell (fx + fy < 1) takes its offset from the near corner,
		// the upper half from the centre minus the far corner.
		if (fx + fy < 65536) begin
			if (fx > fy) begin
				a = h2 - h1;
				b = h5 - h1 - h2;
			end else begin
				a = h5 - h1 - h3;
				b = h3 - h1;
			end
			c = h1;
		end else begin
			if (fx > fy) begin
				a = h2 + h4 - h5;
				b = h4 - h2;
			end else begin
				a = h4 - h3;
				b = h3 + h4 - h5;
			end
			c = h5 - h4;
		end
		h = floor_quot(a * fx + b * fy + 32768, 65536) + c;
		if (h > H_MAX)
			h = H_MAX;
		if (h < H_MIN)
			h = H_MIN;
		res.height = h[HW-1:0];
		return 1'b1;
	endfunction

	task automatic send_beat(input logic [1:0] fn, input logic [7:0] row, input logic [7:0] col,
			input logic [HW-1:0] hv, input logic [HW-1:0] px, input logic [HW-1:0] py,
			input logic fixed, input ground_t fixed_res);
		int gap;
		ground_t res;
		gap = pick_gap(0);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {py, px, hv, col, row};
		do @(posedge clk); while (!s_tready);
		if (ground_height(fn, row, col, hv, px, py, res))
			height_q.push_back(fixed ? fixed_res : res);
		if (fn != FUNC_UNUSED)
			items_sent++;
	endtask

	task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= TILE_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Register writes only happen with the stream drained and the block settled.
	task automatic set_tile(input logic val);
		logic [31:0] rd;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (height_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		apb_xfer(1'b1, {31'd0, val}, rd);
		tile_on = val;
		apb_xfer(1'b0, 32'd0, rd);
		if (rd !== {31'd0, val})
			flag_error($sformatf("tile_present read back %0h, wrote %0h", rd, val));
	endtask

	function automatic logic [HW-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 9))
			0: v = POS_TOP - int'($urandom_range(0, 120));
			1: v = int'($urandom_range(0, 120)) - POS_TOP;
			2, 3, 4: v = int'($urandom_range(0, 17000)) - 8500;
			default: v = int'($urandom_range(0, 2 * POS_TOP)) - POS_TOP;
		endcase
		return v[HW-1:0];
	endfunction

	function automatic logic [HW-1:0] pick_height();
		int v;
		case ($urandom_range(0, 3))
			0: v = int'($urandom);
			1: v = $urandom_range(0, 1) ? H_MAX : H_MIN;
			default: v = int'($urandom_range(0, 131072)) - 65536;
		endcase
		return v[HW-1:0];
	endfunction

	// Loads any missing entry the query will read, and now and then rewrites one.
	task automatic fill_cell(input logic [HW-1:0] px, input logic [HW-1:0] py);
		int cx, cy, r, c;
		longint f;
		grid_pos(px, cx, f);
		grid_pos(py, cy, f);
		for (int k = 0; k < 4; k++) begin
			r = cx + (k & 1);
			c = cy + (k >> 1);
			if (!corner_set[r * CSIDE + c] || $urandom_range(0, 7) == 0)
				send_beat(FUNC_CORNER, r[7:0], c[7:0], pick_height(), HW'($urandom),
					HW'($urandom), 1'b0, NONE);
		end
		if (!centre_set[cx * CELLS + cy] || $urandom_range(0, 7) == 0)
			send_beat(FUNC_CENTRE, cx[7:0], cy[7:0], pick_height(), HW'($urandom),
				HW'($urandom), 1'b0, NONE);
	endtask

	task automatic random_item();
		logic [HW-1:0] px, py;
		logic [7:0] r, c;
		logic [1:0] fn;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			px = pick_coord();
			py = ($urandom_range(0, 9) == 0) ? px : pick_coord();
			if (tile_on)
				fill_cell(px, py);
			send_beat(FUNC_QUERY, 8'($urandom), 8'($urandom), HW'($urandom), px, py, 1'b0, NONE);
		end else if (pick < 90) begin
			fn = $urandom_range(0, 1) ? FUNC_CENTRE : FUNC_CORNER;
			r = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, CELLS));
			c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, CELLS));
			send_beat(fn, r, c, pick_height(), HW'($urandom), HW'($urandom), 1'b0, NONE);
		end else begin
			send_beat(FUNC_UNUSED, 8'($urandom), 8'($urandom), HW'($urandom), HW'($urandom),
				HW'($urandom), 1'b0, NONE);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (height_q.size() == 0) begin
				flag_error($sformatf("unexpected result beat, height %0h", m_tdata));
			end else begin
				want = height_q.pop_front();
				if (m_tdata !== want.height)
					flag_error($sformatf("height %0d, expected %0d",
						$signed(m_tdata), $signed(want.height)));
				if (m_tuser !== want.no_land)
					flag_error($sformatf("no_land %0b, expected %0b", m_tuser, want.no_land));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			gap = pick_gap(1);
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_tvalid));
		end
	end

	initial begin
		int target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		tile_on = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg)
				set_tile(dir_tab[i].cfg_val);
			send_beat(dir_tab[i].fn, dir_tab[i].row, dir_tab[i].col, dir_tab[i].hv,
				dir_tab[i].px, dir_tab[i].py, dir_tab[i].fixed, dir_tab[i].t_res);
		end

		for (int p = 0; p < 5; p++) begin
			set_tile(TILE_PLAN[p]);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_item();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (height_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
